// ===== rtl/tac_pkg.sv =====
package tac_pkg;

  // field widths
  localparam int SAMPLE_W  = 10;
  localparam int SUM_W     = 20;
  localparam int CNT_W     = 11;
  localparam int DEG_W     = 9;
  localparam int VOLTS_W   = 7;

  // averages are taken at x64 scale
  localparam int AVG_SHIFT = 6;
  localparam int AVG_W     = SUM_W + AVG_SHIFT;

  // divider divisor width (sample count or table span)
  localparam int DIV_DSW   = 16;

  // calibration table
  localparam int LEVEL_W   = 16;
  localparam int TENTHS_W  = 12;
  localparam int TAB_N     = 27;
  localparam int TAB_IW    = $clog2(TAB_N);

  localparam logic [LEVEL_W-1:0] CAL_LEVEL [TAB_N] = '{
    16'd61804, 16'd60734, 16'd59440, 16'd57902, 16'd56109, 16'd54058,
    16'd51760, 16'd49233, 16'd46515, 16'd43648, 16'd40681, 16'd37673,
    16'd34676, 16'd31740, 16'd28911, 16'd26224, 16'd23700, 16'd21359,
    16'd19202, 16'd17238, 16'd15455, 16'd13846, 16'd12406, 16'd11111,
    16'd9968,  16'd8942,  16'd8030
  };

  localparam logic signed [TENTHS_W-1:0] CAL_TENTHS [TAB_N] = '{
    -12'sd200, -12'sd150, -12'sd100, -12'sd50, 12'sd0,    12'sd50,
    12'sd100,  12'sd150,  12'sd200,  12'sd250, 12'sd300,  12'sd350,
    12'sd400,  12'sd450,  12'sd500,  12'sd550, 12'sd600,  12'sd650,
    12'sd700,  12'sd750,  12'sd800,  12'sd850, 12'sd900,  12'sd950,
    12'sd1000, 12'sd1050, 12'sd1100
  };

  // tenths C to whole F: trunc(t * 9 / 50) + 32, the divide done by reciprocal
  localparam int TEMP_MUL      = 9;
  localparam int DEG_RECIP_W   = 15;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 15'd20972;
  localparam int DEG_SHIFT     = 20;
  localparam int F_OFFSET      = 32;

  // supply volts x10 = avg * 99 / (1023 * 64), saturated
  localparam int VOLT_MUL_W    = 7;
  localparam logic [VOLT_MUL_W-1:0] VOLT_MUL = 7'd99;
  localparam int VOLT_LIMIT_W  = 23;
  localparam logic [VOLT_LIMIT_W-1:0] VOLT_SAT_LIMIT = 23'd8380416;
  localparam int VOLT_DIV_SH   = 10;
  localparam logic [VOLT_DIV_SH-1:0] VOLT_DIV = 10'd1023;
  localparam logic [VOLTS_W-1:0] VOLTS_MAX = 7'd127;

  // state memory layout
  localparam int ENTRY_W   = 2 * SUM_W;
  localparam int RAM_DEPTH = 2;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [RAM_AW-1:0] ENT_SUMS  = 1'b0;
  localparam logic [RAM_AW-1:0] ENT_COUNT = 1'b1;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_PERIOD = 1'b0;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 11'd30;

  typedef struct packed {
    logic [SAMPLE_W-1:0] thermistor_sample;
    logic [SAMPLE_W-1:0] supply_sample;
  } sample_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] degrees_f;
    logic                    temp_valid;
    logic [VOLTS_W-1:0]      volts_tenths;
  } report_t;

  typedef struct packed {
    logic [SUM_W-1:0] temp_sum;
    logic [SUM_W-1:0] volt_sum;
  } sum_entry_t;

  typedef struct packed {
    logic [ENTRY_W-2*CNT_W-2:0] pad;
    logic                       skip_done;
    logic [CNT_W-1:0]           tick_count;
    logic [CNT_W-1:0]           sample_count;
  } count_entry_t;

  typedef struct packed {
    logic               start;
    logic [AVG_W-1:0]   dividend;
    logic [DIV_DSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/tac_ram.sv =====
module tac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tac_div.sv =====
module tac_div (
  input  logic              clk,
  input  logic              rst,
  input  tac_pkg::div_req_t req,
  output tac_pkg::div_rsp_t rsp
);
  import tac_pkg::*;

  localparam int STEP_W = $clog2(AVG_W);

  logic [AVG_W-1:0]   quo;
  logic [DIV_DSW-1:0] rem;
  logic [DIV_DSW-1:0] den;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [DIV_DSW:0]   trial;
  logic [DIV_DSW:0]   trial_sub;
  logic               fits;

  // one restoring step: bring down the next dividend bit
  assign trial     = {rem, quo[AVG_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits      = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      den  <= req.divisor;
      rem  <= '0;
      step <= STEP_W'(AVG_W - 1);
    end else if (busy) begin
      quo  <= {quo[AVG_W-2:0], fits};
      rem  <= fits ? trial_sub[DIV_DSW-1:0] : trial[DIV_DSW-1:0];
      step <= step - STEP_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/thermistor_average_and_convert.sv =====
// channel   dir  payload    handshake
// sample    in   sample_t   sample_valid / sample_stall
// report    out  report_t   report_valid / report_stall
// config    in   apb        psel / penable / pwrite, pready tied high
//
// A tick that causes no report makes two reads and two writes of
// the two-entry state memory (sums entry, counters entry).
// A report tick makes up to three passes of the shared
// 26-step divider (temperature average, supply average, interpolation) and
// a walk of up to 26 table points, one per cycle.
// Reset clears the period register to 30 and marks both memory entries as
// zero; the first tick after reset or after a report is skipped.
// A report waiting on report_stall holds the next report in its last step.
module thermistor_average_and_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  tac_pkg::sample_t              sample,
  output logic                          report_valid,
  input  logic                          report_stall,
  output tac_pkg::report_t              report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tac_pkg::PADDR_W-1:0]   paddr,
  input  logic [tac_pkg::PDATA_W-1:0]   pwdata,
  output logic [tac_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import tac_pkg::*;

  localparam int T9_W        = TENTHS_W + 4;
  localparam int DEG_PROD_W  = 30;
  localparam int VOLT_PROD_W = AVG_W + VOLT_MUL_W;
  localparam int VB_W        = VOLT_LIMIT_W - AVG_SHIFT;
  localparam int VQ_W        = VB_W - VOLT_DIV_SH;
  localparam int IPROD_W     = LEVEL_W + TENTHS_W;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_RD_COUNT = 11'b00000000010,
    S_UPDATE   = 11'b00000000100,
    S_WRITE    = 11'b00000001000,
    S_DIV_T    = 11'b00000010000,
    S_DIV_V    = 11'b00000100000,
    S_SEARCH   = 11'b00001000000,
    S_MUL      = 11'b00010000000,
    S_DIV_I    = 11'b00100000000,
    S_CONV     = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]     period;
  logic [RAM_DEPTH-1:0] entry_written;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SAMPLE_W-1:0]  thr;
  logic [SAMPLE_W-1:0]  sup;
  logic [SUM_W-1:0]     acc_t;
  logic [SUM_W-1:0]     acc_v;
  logic [CNT_W-1:0]     cnt;
  logic                 rpt;
  logic [AVG_W-1:0]     tavg;
  logic [AVG_W-1:0]     vavg;
  logic                 tvalid;
  logic [TAB_IW-1:0]    k;
  logic [LEVEL_W-1:0]   diff;
  logic signed [TENTHS_W-1:0] t;
  logic [DEG_PROD_W-1:0]  deg_prod;
  logic                   deg_neg;
  logic [VOLT_PROD_W-1:0] volt_prod;

  sum_entry_t           sums_rd;
  count_entry_t         cur;
  count_entry_t         count_wr;
  logic [SUM_W-1:0]     acc_t_upd;
  logic [SUM_W-1:0]     acc_v_upd;
  logic [CNT_W-1:0]     sc_upd;
  logic [CNT_W-1:0]     tick_upd;
  logic                 rpt_upd;

  logic [TENTHS_W-1:0]  step_u;
  logic [LEVEL_W-1:0]   span;
  logic [IPROD_W-1:0]   iprod;
  logic                 level_below;

  logic signed [T9_W-1:0] t9;
  logic [T9_W-1:0]        mag;

  logic [DEG_W-1:0]     deg_q;
  logic [DEG_W-1:0]     deg_val;
  logic                 volt_sat;
  logic [VB_W-1:0]      vb;
  logic [VQ_W-1:0]      vq0;
  logic [VOLT_DIV_SH:0] vr;
  logic [VQ_W:0]        vq;
  report_t              report_next;
  logic                 load_report;

  tac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_PERIOD) ? PDATA_W'(period) : '0;

  assign sample_stall = (state != S_IDLE);

  // entries never written read as zero
  assign sums_rd = entry_written[ENT_SUMS] ? sum_entry_t'(ram_rdata) : '0;
  assign cur     = entry_written[ENT_COUNT] ? count_entry_t'(ram_rdata) : '0;

  // accumulate this tick unless it is the skipped one
  always_comb begin
    acc_t_upd = acc_t;
    acc_v_upd = acc_v;
    sc_upd    = cur.sample_count;
    if (cur.skip_done) begin
      acc_t_upd = acc_t + SUM_W'(thr);
      acc_v_upd = acc_v + SUM_W'(sup);
      sc_upd    = cur.sample_count + CNT_W'(1);
    end
    tick_upd = cur.tick_count + CNT_W'(1);
    rpt_upd  = (tick_upd >= period);
    count_wr = '0;
    if (!rpt_upd) begin
      count_wr.skip_done    = 1'b1;
      count_wr.tick_count   = tick_upd;
      count_wr.sample_count = sc_upd;
    end
  end

  // interpolation segment of the current table point
  assign step_u      = CAL_TENTHS[k] - CAL_TENTHS[k - TAB_IW'(1)];
  assign span        = CAL_LEVEL[k - TAB_IW'(1)] - CAL_LEVEL[k];
  assign iprod       = IPROD_W'(diff) * IPROD_W'(step_u);
  assign level_below = (AVG_W'(CAL_LEVEL[k]) < tavg);

  // sequencer: memory and divider control
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = ENT_SUMS;
    ram_we     = 1'b0;
    ram_waddr  = ENT_SUMS;
    ram_wdata  = '0;
    div_req    = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          ram_re     = 1'b1;
          ram_raddr  = ENT_SUMS;
          state_next = S_RD_COUNT;
        end
      end
      S_RD_COUNT: begin
        ram_re     = 1'b1;
        ram_raddr  = ENT_COUNT;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        ram_we     = 1'b1;
        ram_waddr  = ENT_COUNT;
        ram_wdata  = count_wr;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = ENT_SUMS;
        ram_wdata = rpt ? '0 : {acc_t, acc_v};
        if (!rpt) begin
          state_next = S_IDLE;
        end else if (cnt == '0) begin
          state_next = S_CONV;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {acc_t, {AVG_SHIFT{1'b0}}};
          div_req.divisor  = DIV_DSW'(cnt);
          state_next       = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {acc_v, {AVG_SHIFT{1'b0}}};
          div_req.divisor  = DIV_DSW'(cnt);
          state_next       = S_DIV_V;
        end
      end
      S_DIV_V: begin
        if (div_rsp.done) begin
          state_next = tvalid ? S_SEARCH : S_CONV;
        end
      end
      S_SEARCH: begin
        if (level_below) begin
          state_next = S_MUL;
        end else if (k == TAB_IW'(TAB_N - 1)) begin
          state_next = S_CONV;
        end
      end
      S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = iprod[AVG_W-1:0];
        div_req.divisor  = DIV_DSW'(span);
        state_next       = S_DIV_I;
      end
      S_DIV_I: begin
        if (div_rsp.done) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!report_valid || !report_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // temperature product and its magnitude for the conversion step
  assign t9  = T9_W'(t) * T9_W'(TEMP_MUL);
  assign mag = t9[T9_W-1] ? T9_W'(-t9) : T9_W'(t9);

  // result formatting: truncated F, volts by shift and one correction
  always_comb begin
    deg_q    = deg_prod[DEG_SHIFT+DEG_W-1:DEG_SHIFT];
    deg_val  = (deg_neg ? (DEG_W'(0) - deg_q) : deg_q) + DEG_W'(F_OFFSET);
    volt_sat = (volt_prod >= VOLT_PROD_W'(VOLT_SAT_LIMIT));
    vb       = volt_prod[AVG_SHIFT+VB_W-1:AVG_SHIFT];
    vq0      = vb[VB_W-1:VOLT_DIV_SH];
    vr       = {1'b0, vb[VOLT_DIV_SH-1:0]} + (VOLT_DIV_SH+1)'(vq0);
    vq       = {1'b0, vq0} + (VQ_W+1)'(vr >= {1'b0, VOLT_DIV});
    report_next.degrees_f    = tvalid ? deg_val : '0;
    report_next.temp_valid   = tvalid;
    report_next.volts_tenths = volt_sat ? VOLTS_MAX : vq[VOLTS_W-1:0];
  end

  assign load_report = (state == S_FINISH) && (!report_valid || !report_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      period        <= PERIOD_RESET;
      entry_written <= '0;
      report_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_PERIOD) begin
        period <= pwdata[CNT_W-1:0];
      end
      if (ram_we) begin
        entry_written[ram_waddr] <= 1'b1;
      end
      if (load_report) begin
        report_valid <= 1'b1;
      end else if (!report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          thr <= sample.thermistor_sample;
          sup <= sample.supply_sample;
        end
      end
      S_RD_COUNT: begin
        acc_t <= sums_rd.temp_sum;
        acc_v <= sums_rd.volt_sum;
      end
      S_UPDATE: begin
        acc_t <= acc_t_upd;
        acc_v <= acc_v_upd;
        cnt   <= sc_upd;
        rpt   <= rpt_upd;
      end
      S_WRITE: begin
        if (cnt == '0) begin
          vavg   <= '0;
          tvalid <= 1'b0;
          t      <= '0;
        end
      end
      S_DIV_T: begin
        if (div_rsp.done) begin
          tavg   <= div_rsp.quotient;
          tvalid <= (div_rsp.quotient <= AVG_W'(CAL_LEVEL[0])) &&
                    (div_rsp.quotient >= AVG_W'(CAL_LEVEL[TAB_N-1]));
        end
      end
      S_DIV_V: begin
        if (div_rsp.done) begin
          vavg <= div_rsp.quotient;
          k    <= TAB_IW'(1);
          t    <= '0;
        end
      end
      S_SEARCH: begin
        if (level_below) begin
          diff <= tavg[LEVEL_W-1:0] - CAL_LEVEL[k];
        end else if (k == TAB_IW'(TAB_N - 1)) begin
          // exactly the last point: nothing lies below it
          t <= CAL_TENTHS[TAB_N-1];
        end else begin
          k <= k + TAB_IW'(1);
        end
      end
      S_DIV_I: begin
        if (div_rsp.done) begin
          t <= CAL_TENTHS[k] - $signed({1'b0, div_rsp.quotient[TENTHS_W-2:0]});
        end
      end
      S_CONV: begin
        deg_prod  <= DEG_PROD_W'(mag) * DEG_PROD_W'(DEG_RECIP);
        deg_neg   <= t9[T9_W-1];
        volt_prod <= VOLT_PROD_W'(vavg) * VOLT_PROD_W'(VOLT_MUL);
      end
      S_FINISH: begin
        if (load_report) begin
          report <= report_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/tac_checker.sv =====
module tac_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input logic             report_valid,
  input logic             report_stall,
  input tac_pkg::report_t report
);
  import tac_pkg::*;

  // a sample transfer always starts a busy stretch
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample channel free right after a transfer");

  // a new report only comes out of a busy stretch
  a_report_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(sample_stall))
    else $error("report appeared without processing");

  // a stalled report holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && report_stall |=> report_valid && $stable(report))
    else $error("stalled report changed");

  // out-of-range reading gives zero degrees
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report.temp_valid |-> report.degrees_f == '0)
    else $error("invalid reading with nonzero degrees");

  // in-range reading stays within the table's span in F
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.temp_valid |->
      (report.degrees_f >= -9'sd4) && (report.degrees_f <= 9'sd230))
    else $error("valid reading out of range");

endmodule

bind thermistor_average_and_convert tac_checker u_tac_checker (.*);

// ===== bench/tb_thermistor_average_and_convert.sv =====
`timescale 1ns / 1ps

module tb_thermistor_average_and_convert;
  import tac_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam longint LIMIT_CYCLES = 3_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_TICKS = 1130;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int N_POINTS = 27;
  localparam logic [PADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};

  // calibration points: scaled reading against tenths of a degree C
  localparam int TAB_LEVEL [N_POINTS] = '{
    61804, 60734, 59440, 57902, 56109, 54058, 51760, 49233, 46515,
    43648, 40681, 37673, 34676, 31740, 28911, 26224, 23700, 21359,
    19202, 17238, 15455, 13846, 12406, 11111, 9968, 8942, 8030
  };
  localparam int TAB_TENTHS [N_POINTS] = '{
    -200, -150, -100, -50, 0, 50, 100, 150, 200,
    250, 300, 350, 400, 450, 500, 550, 600, 650,
    700, 750, 800, 850, 900, 950, 1000, 1050, 1100
  };

  typedef enum {MIX_NEAR, MIX_WIDE, MIX_EDGE, MIX_HIGH} content_t;

  // one row of the directed sequence; the row's sample is sent reps times
  typedef struct packed {
    bit               set_cfg;
    logic [CNT_W-1:0] period;
    logic [11:0]      reps;
    sample_t          s;
    bit               typed;
    report_t          want;
  } step_row_t;

  localparam int N_ROWS = 23;
  localparam step_row_t DIRECTED [N_ROWS] = '{
    // period 0 and 1: every tick reports with no samples
    '{1, 0, 1, '{1023, 1023}, 1, '{0, 0, 0}},
    '{0, 0, 1, '{0, 0},       1, '{0, 0, 0}},
    '{1, 1, 1, '{512, 341},   1, '{0, 0, 0}},
    // period 2: one skipped tick, then one sample per report
    '{1, 2, 1, '{0, 0},       0, '{0, 0, 0}},
    '{0, 0, 1, '{1023, 1023}, 1, '{0, 0, 99}},
    '{0, 0, 1, '{1023, 0},    0, '{0, 0, 0}},
    '{0, 0, 1, '{0, 0},       1, '{0, 0, 0}},
    '{0, 0, 1, '{1, 1},       0, '{0, 0, 0}},
    '{0, 0, 1, '{125, 1023},  1, '{0, 0, 99}},
    '{0, 0, 1, '{1, 1},       0, '{0, 0, 0}},
    '{0, 0, 1, '{126, 512},   0, '{0, 0, 0}},
    '{0, 0, 1, '{1, 1},       0, '{0, 0, 0}},
    '{0, 0, 1, '{965, 700},   0, '{0, 0, 0}},
    '{0, 0, 1, '{1, 1},       0, '{0, 0, 0}},
    '{0, 0, 1, '{966, 1},     1, '{0, 0, 0}},
    '{0, 0, 1, '{1, 1},       0, '{0, 0, 0}},
    '{0, 0, 1, '{600, 300},   0, '{0, 0, 0}},
    // average lands exactly on the first table point
    '{1, 17, 1, '{0, 0},      0, '{0, 0, 0}},
    '{0, 0, 11, '{966, 0},    0, '{0, 0, 0}},
    '{0, 0, 5, '{965, 0},     1, '{-4, 1, 0}},
    // average lands exactly on the last table point
    '{1, 33, 1, '{0, 0},      0, '{0, 0, 0}},
    '{0, 0, 31, '{125, 600},  0, '{0, 0, 0}},
    '{0, 0, 1, '{140, 600},   1, '{230, 1, 58}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic report_valid;
  logic report_stall = 1'b0;
  report_t report;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predicted block state
  logic [CNT_W-1:0] period_cfg = PERIOD_RESET;
  logic [CNT_W-1:0] acc_ticks = '0;
  logic [SUM_W-1:0] acc_temp = '0;
  logic [SUM_W-1:0] acc_volt = '0;
  logic [CNT_W-1:0] acc_samples = '0;
  bit acc_primed = 1'b0;

  report_t pending_reports[$];
  int fault_count = 0;
  int random_done = 0;
  int stall_left = 0;

  thermistor_average_and_convert dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fault_count++;
  endtask

  // advance the predicted state by one tick; returns 1 when a report is due
  function automatic bit predict_tick(input sample_t s, output report_t r);
    longint tavg;
    longint vavg;
    longint drop;
    longint volts;
    int t;
    bit found;
    r = '0;
    if (!acc_primed) begin
      acc_primed = 1'b1;
    end else begin
      acc_temp = acc_temp + s.thermistor_sample;
      acc_volt = acc_volt + s.supply_sample;
      acc_samples = acc_samples + 1'b1;
    end
    acc_ticks = acc_ticks + 1'b1;
    if (acc_ticks < period_cfg) return 1'b0;
    acc_ticks = '0;
    if (acc_samples != 0) begin
      tavg = (longint'(acc_temp) << AVG_SHIFT) / longint'(acc_samples);
      vavg = (longint'(acc_volt) << AVG_SHIFT) / longint'(acc_samples);
      // range check, then interpolate below the first point that lies under the average
      if (tavg <= TAB_LEVEL[0] && tavg >= TAB_LEVEL[N_POINTS-1]) begin
        t = TAB_TENTHS[N_POINTS-1];
        found = 1'b0;
        for (int k = 1; k < N_POINTS; k++) begin
          if (!found && TAB_LEVEL[k] < tavg) begin
            drop = (tavg - TAB_LEVEL[k]) * (TAB_TENTHS[k] - TAB_TENTHS[k-1])
                   / (TAB_LEVEL[k-1] - TAB_LEVEL[k]);
            t = TAB_TENTHS[k] - int'(drop);
            found = 1'b1;
          end
        end
        r.degrees_f = t * 9 / 5 / 10 + 32;
        r.temp_valid = 1'b1;
      end
      volts = vavg * 33 * 15 / 5 / (1023 * 64);
      if (volts > 127) volts = 127;
      r.volts_tenths = volts[VOLTS_W-1:0];
    end
    acc_temp = '0;
    acc_volt = '0;
    acc_samples = '0;
    acc_primed = 1'b0;
    return 1'b1;
  endfunction

  // one setup phase and one access phase on the register port
  task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PERIOD_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_period(input logic [CNT_W-1:0] p);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PDATA_W'(p), rd);
    period_cfg = p;
    apb_access(1'b0, '0, rd);
    if (rd[CNT_W-1:0] !== p)
      flag_mismatch($sformatf("period readback got %0d want %0d", rd[CNT_W-1:0], p));
  endtask

  // hold off until every report has come and the block has gone quiet
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // offer one tick, wait for its transfer, then maybe leave a gap
  task automatic send_tick(input sample_t s, input bit typed, input report_t want);
    report_t guess;
    int r;
    int gap;
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall !== 1'b0);
    if (predict_tick(s, guess)) pending_reports.push_back(typed ? want : guess);
    r = $urandom_range(0, 99);
    if (r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one period setting followed by a run of ticks with random content
  task automatic run_phase(input logic [CNT_W-1:0] p, input int ticks, input content_t mix);
    sample_t s;
    int tc;
    int vc;
    int jit;
    int ts;
    int vs;
    settle();
    set_period(p);
    tc = $urandom_range(126, 965);
    vc = $urandom_range(0, SAMPLE_MAX);
    jit = $urandom_range(0, 48);
    if (mix == MIX_EDGE)
      tc = $urandom_range(0, 1) ? $urandom_range(118, 134) : $urandom_range(958, 972);
    for (int n = 0; n < ticks; n++) begin
      case (mix)
        MIX_WIDE: begin
          ts = $urandom_range(0, SAMPLE_MAX);
          vs = $urandom_range(0, SAMPLE_MAX);
        end
        MIX_HIGH: begin
          ts = $urandom_range(900, SAMPLE_MAX);
          vs = $urandom_range(900, SAMPLE_MAX);
        end
        default: begin
          ts = tc + int'($urandom_range(0, 2 * jit)) - jit;
          vs = vc + int'($urandom_range(0, 2 * jit)) - jit;
        end
      endcase
      if (ts < 0) ts = 0;
      if (ts > SAMPLE_MAX) ts = SAMPLE_MAX;
      if (vs < 0) vs = 0;
      if (vs > SAMPLE_MAX) vs = SAMPLE_MAX;
      s.thermistor_sample = ts[SAMPLE_W-1:0];
      s.supply_sample = vs[SAMPLE_W-1:0];
      send_tick(s, 1'b0, '0);
    end
    random_done += ticks;
  endtask

  // receiver stall pattern: calm stretches, short stalls, a few long ones
  always @(posedge clk) begin : stall_pattern
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        report_stall <= 1'b0;
        stall_left <= $urandom_range(100, 300);
      end else if (r < 60) begin
        report_stall <= 1'b0;
        stall_left <= $urandom_range(0, 15);
      end else if (r < 95) begin
        report_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        report_stall <= 1'b1;
        stall_left <= $urandom_range(20, 80);
      end
    end
  end

  // compare each report transfer with the oldest prediction
  always @(posedge clk) begin : report_check
    report_t want;
    if (!rst && report_valid === 1'b1 && report_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("report transfer with none expected");
      end else begin
        want = pending_reports.pop_front();
        if (report.degrees_f !== want.degrees_f)
          flag_mismatch($sformatf("degrees_f got %0d want %0d",
                                  report.degrees_f, want.degrees_f));
        if (report.temp_valid !== want.temp_valid)
          flag_mismatch($sformatf("temp_valid got %0b want %0b",
                                  report.temp_valid, want.temp_valid));
        if (report.volts_tenths !== want.volts_tenths)
          flag_mismatch($sformatf("volts_tenths got %0d want %0d",
                                  report.volts_tenths, want.volts_tenths));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("tb_thermistor_average_and_convert NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [PDATA_W-1:0] rd;
    step_row_t row;
    int r;
    int p;
    int ticks;
    content_t mix;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // period register comes out of reset at its default
    apb_access(1'b0, '0, rd);
    if (rd[CNT_W-1:0] !== PERIOD_RESET)
      flag_mismatch($sformatf("period after reset got %0d", rd[CNT_W-1:0]));

    // directed rows
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.set_cfg) begin
        settle();
        set_period(row.period);
      end
      for (int k = 1; k <= row.reps; k++)
        send_tick(row.s, row.typed && k == row.reps, row.want);
    end

    // random phases, mostly short periods
    while (random_done < RANDOM_TICKS) begin
      r = $urandom_range(0, 99);
      if (r < 8) p = $urandom_range(0, 1);
      else if (r < 70) p = $urandom_range(2, 12);
      else if (r < 94) p = $urandom_range(13, 64);
      else p = $urandom_range(65, 200);
      r = $urandom_range(0, 99);
      if (r < 55) mix = MIX_NEAR;
      else if (r < 75) mix = MIX_WIDE;
      else if (r < 95) mix = MIX_EDGE;
      else mix = MIX_HIGH;
      ticks = $urandom_range(1, 3) * ((p < 2) ? 1 : p) + $urandom_range(0, 3);
      run_phase(p[CNT_W-1:0], ticks, mix);
    end

    settle();
    if (fault_count == 0) begin
      $display("tb_thermistor_average_and_convert OK");
    end else begin
      $display("tb_thermistor_average_and_convert NOT OK");
    end
    $finish;
  end

endmodule
